@@ hw/rtl/lcmt_pkg.sv @@
// ----------------------------------------------------------------------------
// lcmt_pkg: shared types and constants of the line minimum tree
// Word widths, node entry layout, opcodes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lcmt_pkg;

	// default tree size exponent
	localparam int LOG_SIZE_DEF = 10;

	// stored line widths keep one extra bit so that a negated line is exact
	localparam int SLOPE_W = 33;
	localparam int ICPT_W  = 49;
	localparam int X_W     = 33;
	localparam int VAL_W   = 64;

	localparam logic signed [VAL_W-1:0] SENTINEL = {1'b0, {(VAL_W-1){1'b1}}};

	// opcodes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// register indexes
	localparam logic REG_BASE = 1'b0;
	localparam logic REG_MAX  = 1'b1;

	// one tree node in memory
	typedef struct packed {
		logic                      valid;
		logic signed [SLOPE_W-1:0] k;
		logic signed [ICPT_W-1:0]  b;
	} node_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_I_RD,
		ST_I_E0,
		ST_I_E1,
		ST_I_E2,
		ST_I_E3,
		ST_I_DEC,
		ST_Q_RD,
		ST_Q_MUL,
		ST_Q_CMP,
		ST_Q_DONE
	} state_t;

endpackage
`default_nettype wire

@@ hw/rtl/li_chao_line_min_tree.sv @@
// ----------------------------------------------------------------------------
// li_chao_line_min_tree: line minimum tree over 2^LOG_SIZE points
// Insert lines, query the lower (or upper) envelope at a point.
// ----------------------------------------------------------------------------
// After reset a clearing pass walks all 2*2^LOG_SIZE entries of the node
// memory, one entry a cycle; no item is taken meanwhile. All evaluations share
// one 33x33 multiplier, and the block takes one item at a time. A query reads
// the 1+LOG_SIZE nodes from leaf to root, each with a read, a multiply and a
// compare step. An insert takes each node it visits through a read, four
// evaluations and a decide-and-write step: a plain descent visits 1 to
// LOG_SIZE+1 nodes; when a line is pushed into both halves the pending right
// halves wait on a stack of 2**$clog2(LOG_SIZE+1) entries, and in the worst
// case all 2*2^LOG_SIZE-1 nodes are visited. A result waits in its output
// register while the next item is already accepted.
`timescale 1ns / 1ps
`default_nettype none
module li_chao_line_min_tree #(
	parameter int LOG_SIZE = lcmt_pkg::LOG_SIZE_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic                                cfg_index,
	input  wire logic [31:0]                         cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                op,
	input  wire logic signed [31:0]                  slope,
	input  wire logic signed [47:0]                  intercept,
	input  wire logic signed [31:0]                  point,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [lcmt_pkg::VAL_W-1:0]        value,
	output logic                                     no_line,
	output logic                                     out_of_range
);
	localparam int NW    = LOG_SIZE + 1;
	localparam int NODES = 2 ** NW;
	localparam int SPW   = $clog2(LOG_SIZE + 1);
	localparam int STK   = 2 ** SPW;
	localparam int KW    = lcmt_pkg::SLOPE_W;
	localparam int BW    = lcmt_pkg::ICPT_W;
	localparam int XW    = lcmt_pkg::X_W;
	localparam int VW    = lcmt_pkg::VAL_W;

	lcmt_pkg::state_t state_q, state_d;

	// configuration
	logic signed [31:0] base_q;
	logic               max_q;

	// node memory
	lcmt_pkg::node_t mem [NODES];
	lcmt_pkg::node_t rd_q;
	lcmt_pkg::node_t wr_data;
	logic [NW-1:0]   wr_addr;
	logic            wr_en;
	logic [NW-1:0]   clr_cnt_q;

	// current walk
	logic signed [KW-1:0] cur_k_q;
	logic signed [BW-1:0] cur_b_q;
	logic [NW-1:0]        node_q;
	logic [LOG_SIZE-1:0]  lo_q;
	logic [NW-1:0]        span_q;
	logic signed [XW-1:0] px_q;

	// pending right halves
	logic signed [KW-1:0] stk_k  [STK];
	logic signed [BW-1:0] stk_b  [STK];
	logic [NW-1:0]        stk_n  [STK];
	logic [LOG_SIZE-1:0]  stk_lo [STK];
	logic [NW-1:0]        stk_sp [STK];
	logic [SPW-1:0]       sp_q;

	// evaluation results
	logic signed [VW-1:0] pl_q, pr_q, al_q, ar;
	logic signed [VW-1:0] best_q;
	logic                 none_q, oor_q;

	// shared unit operands
	logic                 ev_en;
	logic signed [KW-1:0] ev_k;
	logic signed [XW-1:0] ev_x;
	logic signed [BW-1:0] ev_b;
	logic signed [VW-1:0] ev_res;

	logic signed [XW-1:0] xl, xr;
	logic signed [33:0]   q_off;
	logic                 q_oor;
	logic signed [KW-1:0] in_k, in_kn;
	logic signed [BW-1:0] in_b, in_bn;
	logic                 accept;
	logic                 drop, repl, swap, is_leaf, stk_empty, push, pop, out_load;
	logic [SPW-1:0]       sp_m1;

	lcmt_eval u_eval (
		.clk (clk),
		.en  (ev_en),
		.k   (ev_k),
		.x   (ev_x),
		.b   (ev_b),
		.res (ev_res)
	);

	// interval ends and query offset
	assign xl    = {base_q[31], base_q} + XW'(lo_q);
	assign xr    = xl + XW'(span_q) - XW'(1);
	assign q_off = {{2{point[31]}}, point} - {{2{base_q[31]}}, base_q};
	assign q_oor = q_off[33] || (q_off[32:LOG_SIZE] != '0);
	assign in_k  = {slope[31], slope};
	assign in_kn = -in_k;
	assign in_b  = {intercept[47], intercept};
	assign in_bn = -in_b;

	// node decision
	assign ar        = rd_q.valid ? ev_res : lcmt_pkg::SENTINEL;
	assign drop      = (al_q <= pl_q) && (ar <= pr_q);
	assign repl      = (pl_q <= al_q) && (pr_q <= ar);
	assign swap      = pl_q < al_q;
	assign is_leaf   = node_q[LOG_SIZE];
	assign stk_empty = sp_q == '0;
	assign sp_m1     = sp_q - SPW'(1);

	assign in_stall  = state_q != lcmt_pkg::ST_IDLE;
	assign accept    = in_valid && !in_stall;
	assign out_load  = (state_q == lcmt_pkg::ST_Q_DONE) && (!out_valid || !out_stall);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lcmt_pkg::ST_CLEAR;
		else state_q <= state_d;
	end

	// next state and unit control
	always_comb begin
		state_d = state_q;
		ev_en   = 1'b0;
		ev_k    = rd_q.k;
		ev_x    = xl;
		ev_b    = rd_q.b;
		push    = 1'b0;
		pop     = 1'b0;
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_data = '{valid: 1'b1, k: cur_k_q, b: cur_b_q};
		case (state_q)
			lcmt_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_cnt_q;
				wr_data = '0;
				if (clr_cnt_q == '1) state_d = lcmt_pkg::ST_IDLE;
			end
			lcmt_pkg::ST_IDLE: begin
				if (accept) begin
					if (op == lcmt_pkg::OP_INSERT) state_d = lcmt_pkg::ST_I_RD;
					else if (q_oor) state_d = lcmt_pkg::ST_Q_DONE;
					else state_d = lcmt_pkg::ST_Q_RD;
				end
			end
			lcmt_pkg::ST_I_RD: state_d = lcmt_pkg::ST_I_E0;
			lcmt_pkg::ST_I_E0: begin
				ev_en   = 1'b1;
				ev_k    = cur_k_q;
				ev_b    = cur_b_q;
				state_d = lcmt_pkg::ST_I_E1;
			end
			lcmt_pkg::ST_I_E1: begin
				ev_en   = 1'b1;
				ev_k    = cur_k_q;
				ev_b    = cur_b_q;
				ev_x    = xr;
				state_d = lcmt_pkg::ST_I_E2;
			end
			lcmt_pkg::ST_I_E2: begin
				ev_en   = 1'b1;
				state_d = lcmt_pkg::ST_I_E3;
			end
			lcmt_pkg::ST_I_E3: begin
				ev_en   = 1'b1;
				ev_x    = xr;
				state_d = lcmt_pkg::ST_I_DEC;
			end
			lcmt_pkg::ST_I_DEC: begin
				if (drop) begin
					pop = 1'b1;
				end else if (repl) begin
					wr_en = 1'b1;
					pop   = 1'b1;
				end else begin
					wr_en = swap;
					if (is_leaf) pop = 1'b1;
					else push = 1'b1;
				end
				if (pop && stk_empty) state_d = lcmt_pkg::ST_IDLE;
				else state_d = lcmt_pkg::ST_I_RD;
			end
			lcmt_pkg::ST_Q_RD: state_d = lcmt_pkg::ST_Q_MUL;
			lcmt_pkg::ST_Q_MUL: begin
				ev_en   = 1'b1;
				ev_x    = px_q;
				state_d = lcmt_pkg::ST_Q_CMP;
			end
			lcmt_pkg::ST_Q_CMP: begin
				if (node_q == NW'(1)) state_d = lcmt_pkg::ST_Q_DONE;
				else state_d = lcmt_pkg::ST_Q_RD;
			end
			lcmt_pkg::ST_Q_DONE: begin
				if (out_load) state_d = lcmt_pkg::ST_IDLE;
			end
			default: state_d = lcmt_pkg::ST_IDLE;
		endcase
	end

	// node memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[node_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			max_q     <= 1'b0;
			clr_cnt_q <= '0;
			sp_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == lcmt_pkg::REG_BASE) base_q <= cfg_data;
			if (cfg_we && cfg_index == lcmt_pkg::REG_MAX) max_q <= cfg_data[0];
			if (state_q == lcmt_pkg::ST_CLEAR) clr_cnt_q <= clr_cnt_q + NW'(1);
			if (accept) sp_q <= '0;
			else if (push) sp_q <= sp_q + SPW'(1);
			else if (pop && !stk_empty) sp_q <= sp_m1;
			if (out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			lcmt_pkg::ST_IDLE: begin
				cur_k_q <= max_q ? in_kn : in_k;
				cur_b_q <= max_q ? in_bn : in_b;
				px_q    <= {point[31], point};
				lo_q    <= '0;
				span_q  <= NW'(1) << LOG_SIZE;
				best_q  <= lcmt_pkg::SENTINEL;
				none_q  <= 1'b1;
				oor_q   <= q_oor;
				if (op == lcmt_pkg::OP_INSERT) node_q <= NW'(1);
				else node_q <= {1'b1, q_off[LOG_SIZE-1:0]};
			end
			lcmt_pkg::ST_I_E1: pl_q <= ev_res;
			lcmt_pkg::ST_I_E2: pr_q <= ev_res;
			lcmt_pkg::ST_I_E3: al_q <= rd_q.valid ? ev_res : lcmt_pkg::SENTINEL;
			lcmt_pkg::ST_I_DEC: begin
				if (push) begin
					// carried line goes to the left half now, right half waits
					if (swap) begin
						cur_k_q       <= rd_q.k;
						cur_b_q       <= rd_q.b;
						stk_k[sp_q]   <= rd_q.k;
						stk_b[sp_q]   <= rd_q.b;
					end else begin
						stk_k[sp_q]   <= cur_k_q;
						stk_b[sp_q]   <= cur_b_q;
					end
					stk_n[sp_q]  <= {node_q[NW-2:0], 1'b1};
					stk_lo[sp_q] <= lo_q + LOG_SIZE'(span_q >> 1);
					stk_sp[sp_q] <= span_q >> 1;
					node_q       <= {node_q[NW-2:0], 1'b0};
					span_q       <= span_q >> 1;
				end else if (!stk_empty) begin
					cur_k_q <= stk_k[sp_m1];
					cur_b_q <= stk_b[sp_m1];
					node_q  <= stk_n[sp_m1];
					lo_q    <= stk_lo[sp_m1];
					span_q  <= stk_sp[sp_m1];
				end
			end
			lcmt_pkg::ST_Q_CMP: begin
				if (rd_q.valid) begin
					none_q <= 1'b0;
					if (ev_res < best_q) best_q <= ev_res;
				end
				node_q <= node_q >> 1;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			value        <= max_q ? -best_q : best_q;
			no_line      <= none_q;
			out_of_range <= oor_q;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/lcmt_eval.sv @@
// ----------------------------------------------------------------------------
// lcmt_eval: shared line evaluation unit
// Computes k*x+b with one signed multiplier and a registered result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lcmt_eval (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic signed [lcmt_pkg::SLOPE_W-1:0] k,
	input  wire logic signed [lcmt_pkg::X_W-1:0]     x,
	input  wire logic signed [lcmt_pkg::ICPT_W-1:0]  b,
	output logic signed [lcmt_pkg::VAL_W-1:0]        res
);
	localparam int PW = lcmt_pkg::SLOPE_W + lcmt_pkg::X_W;

	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] sum;

	// multiply and add intercept
	assign prod = k * x;
	assign sum  = prod + PW'(b);

	// result register
	always_ff @(posedge clk) begin
		if (en) res <= sum[lcmt_pkg::VAL_W-1:0];
	end
endmodule
`default_nettype wire

@@ hw/rtl/lcmt_check.sv @@
// ----------------------------------------------------------------------------
// lcmt_check: port level checks of the line minimum tree
// Watches result transfers and their flags; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lcmt_check (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic signed [lcmt_pkg::VAL_W-1:0] value,
	input wire logic                         no_line,
	input wire logic                         out_of_range
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(no_line))
		else $error("stalled result changed");

	// an out of domain point never finds a line
	a_oor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> no_line)
		else $error("out of range result without no_line");

	// an empty result carries the sentinel
	a_sent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_line |-> (value == lcmt_pkg::SENTINEL) || (value == -lcmt_pkg::SENTINEL))
		else $error("empty result without sentinel");

	// a found line means the point was inside the domain
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !no_line |-> !out_of_range)
		else $error("line found for out of range point");
endmodule

bind li_chao_line_min_tree lcmt_check u_lcmt_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.value        (value),
	.no_line      (no_line),
	.out_of_range (out_of_range)
);
`default_nettype wire

@@ test/li_chao_line_min_tree_tb.sv @@
// ----------------------------------------------------------------------------
// li_chao_line_min_tree_tb: self-checking bench of the line minimum tree
// A shadow copy of the tree predicts every query result. Several phases run
// with different base and mode settings and different sender and receiver
// idling. One phase includes a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module li_chao_line_min_tree_tb;

	localparam int LOG_N     = 10;
	localparam int NPTS      = 1 << LOG_N;
	localparam int NODE_CNT  = 2 * NPTS;
	localparam int WDOG_MAX  = 60000;
	localparam int DRAIN_CYC = 13000;
	localparam int HOLD_CYC  = 400;

	typedef struct {
		logic               op;
		logic signed [31:0] slope;
		logic signed [47:0] intercept;
		logic signed [31:0] point;
	} line_item_t;

	typedef struct {
		logic signed [63:0] value;
		logic               no_line;
		logic               out_of_range;
	} envelope_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               op;
	logic signed [31:0] slope;
	logic signed [47:0] intercept;
	logic signed [31:0] point;
	logic               out_valid;
	logic               out_stall;
	logic signed [63:0] value;
	logic               no_line;
	logic               out_of_range;

	li_chao_line_min_tree #(.LOG_SIZE(LOG_N)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .slope(slope), .intercept(intercept), .point(point),
		.out_valid(out_valid), .out_stall(out_stall),
		.value(value), .no_line(no_line), .out_of_range(out_of_range)
	);

	// shadow tree and configuration
	longint  sh_k [NODE_CNT];
	longint  sh_b [NODE_CNT];
	bit      sh_v [NODE_CNT];
	longint  sh_base;
	bit      sh_max;

	line_item_t pending_lines[$];
	envelope_t  expected_env[$];
	int         errors;
	int         sender_idle_pct;
	int         recv_stall_pct;
	int         phase;
	bit         sent;
	int         quiet_cycles;

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	function automatic longint node_at(int n, longint x);
		if (!sh_v[n])
			return lcmt_pkg::SENTINEL;
		return sh_k[n] * x + sh_b[n];
	endfunction

	// recursive descent of one line into the shadow tree
	function automatic void tree_add(longint k, longint b, int n, int lo, int hi);
		longint xl, xr, al, ar, pl, pr, tk, tb;
		int mid;
		if (n == 0 || n >= NODE_CNT || lo > hi)
			return;
		xl = sh_base + lo;
		xr = sh_base + hi;
		al = node_at(n, xl);
		ar = node_at(n, xr);
		pl = k * xl + b;
		pr = k * xr + b;
		if (al <= pl && ar <= pr)
			return;
		if (pl <= al && pr <= ar) begin
			sh_k[n] = k; sh_b[n] = b; sh_v[n] = 1'b1;
			return;
		end
		if (pl < al) begin
			tk = sh_k[n]; tb = sh_b[n];
			sh_k[n] = k; sh_b[n] = b;
			k = tk; b = tb;
		end
		mid = (lo + hi) / 2;
		tree_add(k, b, 2 * n, lo, mid);
		tree_add(k, b, 2 * n + 1, mid + 1, hi);
	endfunction

	// apply one accepted insert to the shadow tree, or predict a query result
	function automatic void predict_envelope(line_item_t it);
		longint k, b, best, off;
		envelope_t e;
		int n;
		if (it.op == lcmt_pkg::OP_INSERT) begin
			k = it.slope;
			b = it.intercept;
			if (sh_max) begin
				k = -k; b = -b;
			end
			tree_add(k, b, 1, 0, NPTS - 1);
			return;
		end
		best = lcmt_pkg::SENTINEL;
		e.no_line = 1'b1;
		e.out_of_range = 1'b0;
		off = longint'(it.point) - sh_base;
		if (off < 0 || off >= NPTS) begin
			e.out_of_range = 1'b1;
		end else begin
			for (n = int'(off) + NPTS; n != 0; n = n >> 1) begin
				if (sh_v[n]) begin
					e.no_line = 1'b0;
					if (node_at(n, it.point) < best)
						best = node_at(n, it.point);
				end
			end
		end
		e.value = sh_max ? -best : best;
		expected_env.push_back(e);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("error %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// input driver: changes at falling edge, payload held while stalled
	always @(negedge clk) begin
		if (!in_valid || sent) begin
			if (pending_lines.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				op        <= pending_lines[0].op;
				slope     <= pending_lines[0].slope;
				intercept <= pending_lines[0].intercept;
				point     <= pending_lines[0].point;
				void'(pending_lines.pop_front());
				in_valid  <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		sent = 1'b0;
	end

	// receiver stall, with one long hold-off on phase two
	int hold_cnt;
	int last_phase;
	always @(negedge clk) begin
		if (phase != last_phase) begin
			last_phase = phase;
			if (phase == 2)
				hold_cnt = HOLD_CYC;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// transfer monitor, checker and watchdog
	always @(posedge clk) begin
		line_item_t it;
		envelope_t e;
		if (arst_n) begin
			quiet_cycles++;
			if (in_valid && !in_stall) begin
				it.op = op; it.slope = slope; it.intercept = intercept; it.point = point;
				predict_envelope(it);
				sent = 1'b1;
				quiet_cycles = 0;
			end
			if (out_valid && !out_stall) begin
				quiet_cycles = 0;
				if (expected_env.size() == 0) begin
					report_mismatch("unexpected result value", value, 0);
				end else begin
					e = expected_env.pop_front();
					if (value !== e.value)
						report_mismatch("value", value, e.value);
					if (no_line !== e.no_line)
						report_mismatch("no_line", no_line, e.no_line);
					if (out_of_range !== e.out_of_range)
						report_mismatch("out_of_range", out_of_range, e.out_of_range);
				end
			end
			if (quiet_cycles >= WDOG_MAX) begin
				$display("li_chao_line_min_tree: mismatch");
				$finish;
			end
		end
	end

	task automatic write_reg(logic idx, logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == lcmt_pkg::REG_BASE)
			sh_base = longint'($signed(data));
		else
			sh_max = data[0];
	endtask

	function automatic line_item_t make_line(logic signed [31:0] k, logic signed [47:0] b);
		line_item_t it;
		it.op = lcmt_pkg::OP_INSERT; it.slope = k; it.intercept = b; it.point = $urandom;
		return it;
	endfunction

	function automatic line_item_t make_query(longint off);
		line_item_t it;
		it.op = lcmt_pkg::OP_QUERY; it.point = 32'(sh_base + off);
		it.slope = $urandom; it.intercept = 48'({$urandom, $urandom});
		return it;
	endfunction

	// random line: mostly small slopes so crossings land inside the domain
	function automatic line_item_t rand_line();
		logic signed [31:0] k;
		logic signed [47:0] b;
		if ($urandom_range(9) < 8) begin
			k = $signed($urandom_range(4000)) - 2000;
			b = $signed(48'($urandom_range(2000000))) - 1000000 - 48'(longint'(k) * 512);
		end else begin
			k = $urandom;
			b = 48'({$urandom, $urandom});
			if (k == 32'sh8000_0000) k = 32'sh8000_0001;
			if (b == 48'sh8000_0000_0000) b = 48'sh8000_0000_0001;
		end
		return make_line(k, b);
	endfunction

	task automatic run_phase(int ph, logic [31:0] base, logic maxm, int sidle, int rstall,
			int count);
		int i;
		write_reg(lcmt_pkg::REG_BASE, base);
		write_reg(lcmt_pkg::REG_MAX, {31'b0, maxm});
		sender_idle_pct = sidle;
		recv_stall_pct  = rstall;
		phase = ph;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(99) < 45)
				pending_lines.push_back(rand_line());
			else if ($urandom_range(99) < 90)
				pending_lines.push_back(make_query($urandom_range(NPTS - 1)));
			else
				pending_lines.push_back(make_query(longint'($signed($urandom))));
		end
		while (pending_lines.size() > 0 || in_valid || expected_env.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	initial begin
		errors = 0; phase = 0; last_phase = 0; hold_cnt = 0; sent = 0; quiet_cycles = 0;
		sender_idle_pct = 0; recv_stall_pct = 0;
		sh_base = 0; sh_max = 0;
		for (int n = 0; n < NODE_CNT; n++) begin
			sh_v[n] = 0; sh_k[n] = 0; sh_b[n] = 0;
		end
		arst_n = 1'b0; cfg_we = 1'b0; cfg_index = lcmt_pkg::REG_BASE; cfg_data = '0;
		in_valid = 1'b0; op = lcmt_pkg::OP_INSERT; slope = '0; intercept = '0; point = '0;
		out_stall = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty tree, domain edges, extreme operands
		pending_lines.push_back(make_query(0));
		pending_lines.push_back(make_query(NPTS - 1));
		pending_lines.push_back(make_query(-1));
		pending_lines.push_back(make_query(NPTS));
		pending_lines.push_back(make_line(32'sd5, 48'sd100));
		pending_lines.push_back(make_query(0));
		pending_lines.push_back(make_line(-32'sd3, 48'sd2000));
		pending_lines.push_back(make_line(32'sd7, 48'sd999999));
		pending_lines.push_back(make_query(0));
		pending_lines.push_back(make_query(300));
		pending_lines.push_back(make_query(NPTS - 1));
		pending_lines.push_back(make_line(32'sh7fff_ffff, 48'sh7fff_ffff_ffff));
		pending_lines.push_back(make_line(32'sh8000_0001, 48'sh8000_0000_0001));
		pending_lines.push_back(make_line(32'sd0, -48'sd5));
		pending_lines.push_back(make_query(0));
		pending_lines.push_back(make_query(512));
		pending_lines.push_back(make_query(NPTS - 1));
		pending_lines.push_back(make_query(-1000000));

		run_phase(0, 32'd0, 1'b0, 0, 0, 320);
		run_phase(1, 32'h8000_0000, 1'b1, 74, 0, 320);
		run_phase(2, 32'h7fff_fc00, 1'b0, 0, 74, 320);
		run_phase(3, $urandom, 1'b1, 16, 16, 320);
		run_phase(4, 32'h7fff_ffff, 1'b0, 0, 0, 320);

		if (errors == 0)
			$display("li_chao_line_min_tree: match");
		else
			$display("li_chao_line_min_tree: mismatch");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/lcmt_pkg.sv
hw/rtl/lcmt_eval.sv
hw/rtl/li_chao_line_min_tree.sv
hw/rtl/lcmt_check.sv
test/li_chao_line_min_tree_tb.sv
